>>> hw/rtl/ppc_pkg.sv
// Package for the packet pacer with carry-over.
// Holds the event and verdict codes and the fixed-point widths and defaults.
// No dependencies.
package ppc_pkg;

  localparam int unsigned TimeWidthDefault    = 32;
  localparam int unsigned PayloadWidthDefault = 20;

  // Q16.16 ticks per bit register
  localparam int unsigned TpbWidth = 32;
  localparam logic [TpbWidth-1:0] TpbReset = 32'h0001_0000;

  // fixed-point interval and carry widths (ticks, 16 fraction bits)
  localparam int unsigned QWidth     = 56;
  localparam int unsigned LeftWidth  = 60;
  localparam int unsigned TlWidth    = 40;
  localparam int unsigned BitsWidth  = 32;
  localparam int unsigned FracBits   = 16;

  typedef enum logic [1:0] {
    OP_CHECK     = 2'd0,
    OP_SENT      = 2'd1,
    OP_NEW_IVAL  = 2'd2,
    OP_RESET     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    VERDICT_WAIT_FAR  = 2'd0,
    VERDICT_WAIT_NEAR = 2'd1,
    VERDICT_SEND      = 2'd2,
    VERDICT_BURST     = 2'd3
  } verdict_e;

endpackage

>>> hw/rtl/packet_pacer_carryover_unit.sv
// Packet pacer with carry-over: top level.
// Uses ppc_pkg for event codes, verdict codes and fixed-point widths.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one event per beat:
//   op_i, now_i and payload_bits_i. Output channel (out_valid_o /
//   out_stall_i) returns one result beat per event: verdict_o and the
//   signed whole ticks left, time_left_o.
//   A beat is taken in an input register, processed by the multiplier,
//   subtract and compare logic (which also updates the pacer state), and
//   lands in the result register, which raises out_valid_o; throughput
//   is one event per cycle while out_stall_i is low.
//   The single multiplier (bits times ticks per bit) sets the cycle.
//   When the receiver stalls, the result register holds; the input register
//   keeps one more beat, after which in_stall_o is raised.
//   cfg_we_i / cfg_wdata_i write ticks_per_bit (unsigned Q16.16); write it
//   only while no events are in flight.
//   Reset (rst_ni low) empties both registers, clears all pacer state and
//   sets ticks_per_bit to 1.0 ticks per bit.
module packet_pacer_carryover_unit import ppc_pkg::*; #(
  parameter int unsigned TIME_WIDTH    = TimeWidthDefault,
  parameter int unsigned PAYLOAD_WIDTH = PayloadWidthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  op_i,
  input  logic [TIME_WIDTH-1:0]       now_i,
  input  logic [PAYLOAD_WIDTH-1:0]    payload_bits_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  verdict_o,
  output logic signed [TlWidth-1:0]   time_left_o,
  input  logic                        cfg_we_i,
  input  logic [TpbWidth-1:0]         cfg_wdata_i
);

  localparam logic [QWidth-1:0] QMax = {QWidth{1'b1}};

  // handshake and beat registers
  logic                     in_vld_q;
  op_e                      in_op_q;
  logic [TIME_WIDTH-1:0]    in_now_q;
  logic [PAYLOAD_WIDTH-1:0] in_pay_q;
  logic                     out_vld_q;
  logic [1:0]               verdict_q, verdict_d;
  logic signed [TlWidth-1:0] tl_q, tl_d;
  logic                     out_free;
  logic                     fire;

  // pacer state
  logic [TpbWidth-1:0]      tpb_q;
  logic [TIME_WIDTH-1:0]    ival_start_q, ival_start_d;
  logic [TIME_WIDTH-1:0]    latched_q, latched_d;
  logic [TIME_WIDTH-1:0]    elapsed_q, elapsed_d;
  logic signed [QWidth-1:0] carry_q, carry_d;
  logic [BitsWidth-1:0]     acc_q, acc_d;

  // datapath
  logic [TIME_WIDTH-1:0]    elapsed_cur;
  logic [47:0]              elapsed_ext;
  logic [QWidth-1:0]        elapsed_fix;
  logic [BitsWidth:0]       acc_sum;
  logic [BitsWidth-1:0]     acc_sat;
  logic [BitsWidth-1:0]     mul_bits;
  logic [63:0]              prod;
  logic [QWidth-1:0]        ival_fix;
  logic signed [LeftWidth-1:0] ival_s, elap_s, carry_s;
  logic signed [LeftWidth-1:0] left, left_x2, left_neg, carry_new;
  logic signed [LeftWidth-FracBits-1:0] whole;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_op_q  <= op_e'(op_i);
      in_now_q <= now_i;
      in_pay_q <= payload_bits_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      verdict_q <= verdict_d;
      tl_q      <= tl_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpb_q <= TpbReset;
    end else if (cfg_we_i) begin
      tpb_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ival_start_q <= '0;
      latched_q    <= '0;
      elapsed_q    <= '0;
      carry_q      <= '0;
      acc_q        <= '0;
    end else if (fire) begin
      ival_start_q <= ival_start_d;
      latched_q    <= latched_d;
      elapsed_q    <= elapsed_d;
      carry_q      <= carry_d;
      acc_q        <= acc_d;
    end
  end

  // elapsed time: fresh for a check, stored otherwise
  assign elapsed_cur = (in_op_q == OP_CHECK) ? (in_now_q - ival_start_q) : elapsed_q;
  assign elapsed_ext = 48'(elapsed_cur);
  assign elapsed_fix = (|elapsed_ext[47:40]) ? QMax : {elapsed_ext[39:0], 16'h0000};

  assign acc_sum = {1'b0, acc_q} + (BitsWidth+1)'(in_pay_q);
  assign acc_sat = acc_sum[BitsWidth] ? {BitsWidth{1'b1}} : acc_sum[BitsWidth-1:0];

  always_comb begin
    unique case (in_op_q)
      OP_CHECK: mul_bits = BitsWidth'(in_pay_q);
      OP_SENT:  mul_bits = acc_sat;
      default:  mul_bits = (acc_q == '0) ? BitsWidth'(1) : acc_q;
    endcase
  end

  assign prod     = 64'(mul_bits) * 64'(tpb_q);
  assign ival_fix = (|prod[63:QWidth]) ? QMax : prod[QWidth-1:0];

  assign ival_s  = $signed({{(LeftWidth-QWidth){1'b0}}, ival_fix});
  assign elap_s  = $signed({{(LeftWidth-QWidth){1'b0}}, elapsed_fix});
  assign carry_s = {{(LeftWidth-QWidth){carry_q[QWidth-1]}}, carry_q};

  assign left      = ival_s - elap_s - carry_s;
  assign left_x2   = left <<< 1;
  assign left_neg  = -left;
  assign carry_new = elap_s + carry_s - ival_s;
  // floor of the signed Q44.16 value
  assign whole     = left[LeftWidth-1:FracBits];

  always_comb begin
    verdict_d    = VERDICT_WAIT_FAR;
    tl_d         = '0;
    ival_start_d = ival_start_q;
    latched_d    = latched_q;
    elapsed_d    = elapsed_q;
    carry_d      = carry_q;
    acc_d        = acc_q;

    unique case (in_op_q)
      OP_CHECK, OP_SENT: begin
        if (in_op_q == OP_CHECK) begin
          latched_d = in_now_q;
          elapsed_d = elapsed_cur;
        end else begin
          acc_d = acc_sat;
        end
        if (left > 0) begin
          verdict_d = (left_x2 < ival_s) ? VERDICT_WAIT_NEAR : VERDICT_WAIT_FAR;
        end else begin
          verdict_d = (left_neg > ival_s) ? VERDICT_BURST : VERDICT_SEND;
        end
        // saturate to the output width
        if (whole[LeftWidth-FracBits-1:TlWidth-1] == '0 ||
            whole[LeftWidth-FracBits-1:TlWidth-1] == '1) begin
          tl_d = whole[TlWidth-1:0];
        end else if (whole[LeftWidth-FracBits-1]) begin
          tl_d = {1'b1, {(TlWidth-1){1'b0}}};
        end else begin
          tl_d = {1'b0, {(TlWidth-1){1'b1}}};
        end
      end
      OP_NEW_IVAL: begin
        if (carry_new[LeftWidth-1:QWidth-1] == '0 ||
            carry_new[LeftWidth-1:QWidth-1] == '1) begin
          carry_d = carry_new[QWidth-1:0];
        end else if (carry_new[LeftWidth-1]) begin
          carry_d = {1'b1, {(QWidth-1){1'b0}}};
        end else begin
          carry_d = {1'b0, {(QWidth-1){1'b1}}};
        end
        ival_start_d = latched_q;
        acc_d        = '0;
      end
      default: begin
        ival_start_d = in_now_q;
        latched_d    = in_now_q;
        elapsed_d    = '0;
        carry_d      = '0;
        acc_d        = '0;
      end
    endcase
  end

  assign out_valid_o = out_vld_q;
  assign verdict_o   = verdict_q;
  assign time_left_o = tl_q;

endmodule
